// ===== rtl/accel_tilt_roll_pitch_assert.svh =====
// Assertion helpers for the tilt block checkers.
// ATRP_ASSERT is gated off while reset is high, ATRP_ASSERT_RST is not.
`ifndef ACCEL_TILT_ROLL_PITCH_ASSERT_SVH
`define ACCEL_TILT_ROLL_PITCH_ASSERT_SVH

`define ATRP_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tilt block check failed");

`define ATRP_ASSERT_RST(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("tilt block reset check failed");

`endif

// ===== rtl/atrp_pkg.sv =====
package atrp_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int AXIS_W     = SAMPLE_W + 1;
   localparam int ROLL_W     = 16;
   localparam int PITCH_W    = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_TAB_LEN = 24;
   localparam int STEPS        = (CORDIC_STEPS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STEPS;
   localparam int TAB_IDX_W    = $clog2(ATAN_TAB_LEN);

   // datapath widths
   localparam int OPERAND_SHIFT = 14;
   localparam int SQ_W          = 2 * SAMPLE_W + 1;   // one square, unsigned
   localparam int SUM_W         = SQ_W + 1;
   localparam int SQRT_SHIFT    = 28;
   localparam int SQ_N_W        = SUM_W + SQRT_SHIFT;
   localparam int SQRT_STAGES   = SQ_N_W / 2;
   localparam int ROOT_W        = SQRT_STAGES;
   localparam int SQ_REM_W      = ROOT_W + 2;
   localparam int DP_W          = 36;
   localparam int ACC_W         = 25;

   localparam logic signed [ACC_W-1:0] HALF_PI = 25'sd2304000;
   localparam logic signed [ROLL_W-1:0] ROLL_LIM  = 16'sd18000;
   localparam logic signed [ROLL_W-1:0] PITCH_LIM = 16'sd9000;

   // atan(2^-i) in 1/25600 degree
   localparam logic signed [ACC_W-1:0] ATAN_TAB [ATAN_TAB_LEN] = '{
      25'sd1152000, 25'sd680065, 25'sd359328, 25'sd182400,
      25'sd91554,   25'sd45822,  25'sd22916,  25'sd11459,
      25'sd5730,    25'sd2865,   25'sd1432,   25'sd716,
      25'sd358,     25'sd179,    25'sd90,     25'sd45,
      25'sd22,      25'sd11,     25'sd6,      25'sd3,
      25'sd1,       25'sd1,      25'sd0,      25'sd0
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_ENABLE = 2'd0,
      CSR_OFFSET_X      = 2'd1,
      CSR_OFFSET_Y      = 2'd2,
      CSR_OFFSET_Z      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] z;
   } axis_type;

   typedef struct packed {
      logic signed [DP_W-1:0]  x;
      logic signed [DP_W-1:0]  y;
      logic signed [ACC_W-1:0] acc;
      logic                    zero;
   } cordic_type;

endpackage

// ===== rtl/atrp_if.sv =====
interface atrp_req_if;
   import atrp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [SAMPLE_W-1:0] accel_x;
   logic signed [SAMPLE_W-1:0] accel_y;
   logic signed [SAMPLE_W-1:0] accel_z;
   modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface atrp_rsp_if;
   import atrp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [ROLL_W-1:0]  roll_centideg;
   logic signed [PITCH_W-1:0] pitch_centideg;
   modport source (output valid, output roll_centideg, output pitch_centideg, input ready);
   modport sink   (input valid, input roll_centideg, input pitch_centideg, output ready);
endinterface

// ===== rtl/accel_tilt_roll_pitch.sv =====
// Accelerometer tilt: roll = atan2(y, z), pitch = atan2(-x, sqrt(y^2 + z^2)),
// both in hundredths of a degree, from one raw three-axis sample per item.
// req_chan carries accel_x/y/z; rsp_chan carries roll_centideg/pitch_centideg.
// csr_we/csr_index/csr_wdata write offset_enable and the three axis offsets;
// write them only while no item is in flight.
// The pipe holds 36 + CORDIC_STEPS registers: offset, square, sum, one root bit
// per stage over 31 stages, quadrant fold, one micro-rotation per stage, round
// and clamp; rsp_chan.valid is the valid bit of that last register.
// Throughput is one item per cycle while the receiver does not stall; every stage holds one item.
// The whole pipeline advances together whenever the output register is empty
// or is being taken. When the receiver stalls with a result held, req ready
// drops and every stage freezes; nothing is lost or repeated.
// Reset clears all valid bits and the offset registers (offsets off, zero).
module accel_tilt_roll_pitch (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [atrp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [atrp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   atrp_req_if.sink                         req_chan,
   atrp_rsp_if.source                       rsp_chan
);
   import atrp_pkg::*;

   localparam int LANES = 2;   // lane 0 roll, lane 1 pitch
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

   function automatic cordic_type pre_rot(logic signed [DP_W-1:0] x, logic signed [DP_W-1:0] y);
      cordic_type r;
      r.zero = 1'b0;
      if (x[DP_W-1]) begin
         if (!y[DP_W-1]) begin
            r.x   = y;
            r.y   = -x;
            r.acc = HALF_PI;
         end else begin
            r.x   = -y;
            r.y   = x;
            r.acc = -HALF_PI;
         end
      end else begin
         r.x   = x;
         r.y   = y;
         r.acc = '0;
      end
      return r;
   endfunction

   function automatic cordic_type cordic_step(cordic_type c, logic [TAB_IDX_W-1:0] i);
      cordic_type r;
      logic signed [DP_W-1:0] cx;
      logic signed [DP_W-1:0] cy;
      logic signed [DP_W-1:0] xs;
      logic signed [DP_W-1:0] ys;
      cx = c.x;
      cy = c.y;
      xs = cx >>> i;
      ys = cy >>> i;
      r  = c;
      if (!cy[DP_W-1]) begin
         r.x   = cx + ys;
         r.y   = cy - xs;
         r.acc = c.acc + ATAN_TAB[i];
      end else begin
         r.x   = cx - ys;
         r.y   = cy + xs;
         r.acc = c.acc - ATAN_TAB[i];
      end
      return r;
   endfunction

   // accumulator / 256, half away from zero, then clamp to +-lim
   function automatic logic signed [ROLL_W-1:0] to_cd(logic signed [ACC_W-1:0] acc,
                                                     logic signed [ROLL_W-1:0] lim);
      logic [ACC_W-1:0]  mag;
      logic [ACC_W-1:0]  rnd;
      logic [ROLL_W-1:0] r;
      mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      rnd = (mag + ROUND_HALF) >> 8;
      r   = (rnd > ACC_W'(lim)) ? ROLL_W'(lim) : rnd[ROLL_W-1:0];
      return acc[ACC_W-1] ? ROLL_W'(-r) : ROLL_W'(r);
   endfunction

   // configuration
   logic                       offset_enable_ff;
   logic signed [SAMPLE_W-1:0] offset_x_ff;
   logic signed [SAMPLE_W-1:0] offset_y_ff;
   logic signed [SAMPLE_W-1:0] offset_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_enable_ff <= 1'b0;
         offset_x_ff      <= '0;
         offset_y_ff      <= '0;
         offset_z_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OFFSET_ENABLE: offset_enable_ff <= csr_wdata[0];
            CSR_OFFSET_X:      offset_x_ff      <= csr_wdata;
            CSR_OFFSET_Y:      offset_y_ff      <= csr_wdata;
            CSR_OFFSET_Z:      offset_z_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   logic out_v_ff;
   assign en             = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // stage A: offset removal (17-bit difference never overflows)
   axis_type a_ax_in, a_ax_ff;
   logic     a_v_ff;

   always_comb begin
      a_ax_in.x = {req_chan.accel_x[SAMPLE_W-1], req_chan.accel_x};
      a_ax_in.y = {req_chan.accel_y[SAMPLE_W-1], req_chan.accel_y};
      a_ax_in.z = {req_chan.accel_z[SAMPLE_W-1], req_chan.accel_z};
      if (offset_enable_ff) begin
         a_ax_in.x = a_ax_in.x - {offset_x_ff[SAMPLE_W-1], offset_x_ff};
         a_ax_in.y = a_ax_in.y - {offset_y_ff[SAMPLE_W-1], offset_y_ff};
         a_ax_in.z = a_ax_in.z - {offset_z_ff[SAMPLE_W-1], offset_z_ff};
      end
   end

   // stage B: squares
   logic signed [2*AXIS_W-1:0] b_yy_full, b_zz_full;
   logic [SQ_W-1:0] b_yy_ff, b_zz_ff;
   axis_type        b_ax_ff;
   logic            b_v_ff;
   assign b_yy_full = a_ax_ff.y * a_ax_ff.y;
   assign b_zz_full = a_ax_ff.z * a_ax_ff.z;

   // stage C: sum of squares
   logic [SUM_W-1:0] c_sum_in, c_sum_ff;
   axis_type         c_ax_ff;
   logic             c_v_ff;
   assign c_sum_in = {1'b0, b_yy_ff} + {1'b0, b_zz_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_chan.valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
      if (en) begin
         a_ax_ff  <= a_ax_in;
         b_ax_ff  <= a_ax_ff;
         b_yy_ff  <= b_yy_full[SQ_W-1:0];
         b_zz_ff  <= b_zz_full[SQ_W-1:0];
         c_ax_ff  <= b_ax_ff;
         c_sum_ff <= c_sum_in;
      end
   end

   // integer square root of sum << 28, one root bit per stage
   logic [SQ_REM_W-1:0] sq_rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0]   sq_root_ff [SQRT_STAGES];
   logic [SQ_N_W-1:0]   sq_n_ff    [SQRT_STAGES];
   axis_type            sq_ax_ff   [SQRT_STAGES];
   logic                sq_v_ff    [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      logic [SQ_REM_W-1:0] rem_src;
      logic [ROOT_W-1:0]   root_src;
      logic [SQ_N_W-1:0]   n_src;
      axis_type            ax_src;
      logic                v_src;
      logic [SQ_REM_W+1:0] rem_x;
      logic [SQ_REM_W+1:0] trial;
      logic [SQ_REM_W+1:0] diff;
      logic                take;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign n_src    = {c_sum_ff, {SQRT_SHIFT{1'b0}}};
         assign ax_src   = c_ax_ff;
         assign v_src    = c_v_ff;
      end else begin : g_next
         assign rem_src  = sq_rem_ff[k-1];
         assign root_src = sq_root_ff[k-1];
         assign n_src    = sq_n_ff[k-1];
         assign ax_src   = sq_ax_ff[k-1];
         assign v_src    = sq_v_ff[k-1];
      end

      assign rem_x = {rem_src, n_src[SQ_N_W-1 -: 2]};
      assign trial = {{(SQ_REM_W-ROOT_W){1'b0}}, root_src, 2'b01};
      assign diff  = rem_x - trial;
      assign take  = (rem_x >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (en) begin
            sq_v_ff[k] <= v_src;
         end
         if (en) begin
            sq_rem_ff[k]  <= take ? diff[SQ_REM_W-1:0] : rem_x[SQ_REM_W-1:0];
            sq_root_ff[k] <= {root_src[ROOT_W-2:0], take};
            sq_n_ff[k]    <= {n_src[SQ_N_W-3:0], 2'b00};
            sq_ax_ff[k]   <= ax_src;
         end
      end
   end

   // quadrant fold, then one micro-rotation per stage in both lanes
   cordic_type cd_ff [LANES][STEPS+1];
   logic       cv_ff [STEPS+1];

   axis_type               p_ax;
   logic [ROOT_W-1:0]      p_root;
   logic signed [AXIS_W:0] p_negx;
   logic signed [DP_W-1:0] roll_x0, roll_y0, pitch_x0, pitch_y0;
   cordic_type             roll_pre, pitch_pre;

   always_comb begin
      p_ax     = sq_ax_ff[SQRT_STAGES-1];
      p_root   = sq_root_ff[SQRT_STAGES-1];
      p_negx   = -{p_ax.x[AXIS_W-1], p_ax.x};
      roll_x0  = {{(DP_W-AXIS_W-OPERAND_SHIFT){p_ax.z[AXIS_W-1]}}, p_ax.z, {OPERAND_SHIFT{1'b0}}};
      roll_y0  = {{(DP_W-AXIS_W-OPERAND_SHIFT){p_ax.y[AXIS_W-1]}}, p_ax.y, {OPERAND_SHIFT{1'b0}}};
      pitch_x0 = {{(DP_W-ROOT_W){1'b0}}, p_root};
      pitch_y0 = {{(DP_W-AXIS_W-1-OPERAND_SHIFT){p_negx[AXIS_W]}}, p_negx,
                  {OPERAND_SHIFT{1'b0}}};
      roll_pre       = pre_rot(roll_x0, roll_y0);
      roll_pre.zero  = (p_ax.y == '0) && (p_ax.z == '0);
      pitch_pre      = pre_rot(pitch_x0, pitch_y0);
      pitch_pre.zero = (p_ax.x == '0) && (p_root == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (en) begin
         cv_ff[0] <= sq_v_ff[SQRT_STAGES-1];
      end
      if (en) begin
         cd_ff[0][0] <= roll_pre;
         cd_ff[1][0] <= pitch_pre;
      end
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[s] <= 1'b0;
         end else if (en) begin
            cv_ff[s] <= cv_ff[s-1];
         end
         if (en) begin
            cd_ff[0][s] <= cordic_step(cd_ff[0][s-1], TAB_IDX_W'(s-1));
            cd_ff[1][s] <= cordic_step(cd_ff[1][s-1], TAB_IDX_W'(s-1));
         end
      end
   end

   // output register: round and clamp
   logic signed [ROLL_W-1:0]  roll_in, pitch_full;
   logic signed [ROLL_W-1:0]  rsp_roll_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;

   assign roll_in    = cd_ff[0][STEPS].zero ? '0 : to_cd(cd_ff[0][STEPS].acc, ROLL_LIM);
   assign pitch_full = cd_ff[1][STEPS].zero ? '0 : to_cd(cd_ff[1][STEPS].acc, PITCH_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= cv_ff[STEPS];
      end
      if (en) begin
         rsp_roll_ff  <= roll_in;
         rsp_pitch_ff <= pitch_full[PITCH_W-1:0];
      end
   end

   assign rsp_chan.valid          = out_v_ff;
   assign rsp_chan.roll_centideg  = rsp_roll_ff;
   assign rsp_chan.pitch_centideg = rsp_pitch_ff;

endmodule

// ===== rtl/atrp_check.sv =====
`include "accel_tilt_roll_pitch_assert.svh"

module atrp_check (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [atrp_pkg::ROLL_W-1:0]   roll,
   input logic signed [atrp_pkg::PITCH_W-1:0]  pitch
);
   import atrp_pkg::*;

   // a held result keeps its value
   `ATRP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(roll) && $stable(pitch))

   // pipeline only stalls on a full output register
   `ATRP_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready)

   // angles stay in range
   `ATRP_ASSERT(a_angle_range, rsp_valid |-> (roll >= -ROLL_LIM) && (roll <= ROLL_LIM) && (pitch >= -PITCH_LIM) && (pitch <= PITCH_LIM))

   // no item survives reset
   `ATRP_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid)

   // a valid result carries known angles
   `ATRP_ASSERT(a_rsp_known, rsp_valid |-> !$isunknown(roll) && !$isunknown(pitch))

endmodule

bind accel_tilt_roll_pitch atrp_check u_atrp_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .roll      (rsp_chan.roll_centideg),
   .pitch     (rsp_chan.pitch_centideg)
);

// ===== tb/tilt_scoreboard.sv =====
`timescale 1ns / 1ps
class tilt_scoreboard;
   typedef struct {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
   } angle_pair_type;

   angle_pair_type pending[$];
   int mismatches;
   int orphans;
   bit offset_on;
   logic signed [15:0] off_x, off_y, off_z;

   function void new_reset();
      offset_on = 0;
      off_x = 0;
      off_y = 0;
      off_z = 0;
   endfunction

   function void write_reg(atrp_pkg::csr_index_type idx, logic [15:0] wdata);
      case (idx)
         atrp_pkg::CSR_OFFSET_ENABLE: offset_on = wdata[0];
         atrp_pkg::CSR_OFFSET_X: off_x = wdata;
         atrp_pkg::CSR_OFFSET_Y: off_y = wdata;
         atrp_pkg::CSR_OFFSET_Z: off_z = wdata;
         default: ;
      endcase
   endfunction

   static function longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   static function longint int_root(longint unsigned n);
      longint unsigned op, res, b;
      op = n;
      res = 0;
      b = 64'd1 << 62;
      while (b > op) b >>= 2;
      while (b != 0) begin
         if (op >= res + b) begin
            op -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   // angle of (xv, yv) in 1/25600 degree
   static function longint vector_angle(longint yv, longint xv);
      longint vx, vy, acc, t, xs, ys;
      vx = xv;
      vy = yv;
      acc = 0;
      if (vx == 0 && vy == 0) return 0;
      if (vx < 0) begin
         t = vx;
         if (vy >= 0) begin
            vx = vy; vy = -t; acc = 2304000;
         end else begin
            vx = -vy; vy = t; acc = -2304000;
         end
      end
      for (int i = 0; i < atrp_pkg::STEPS; i++) begin
         xs = shr_floor(vx, i);
         ys = shr_floor(vy, i);
         if (vy >= 0) begin
            vx = vx + ys; vy = vy - xs; acc += atrp_pkg::ATAN_TAB[i];
         end else begin
            vx = vx - ys; vy = vy + xs; acc -= atrp_pkg::ATAN_TAB[i];
         end
      end
      return acc;
   endfunction

   static function longint centideg(longint acc, longint lim);
      longint r;
      if (acc >= 0) r = (acc + 128) >>> 8;
      else r = -((-acc + 128) >>> 8);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   static function longint clip17(longint v);
      if (v > 65535) return 65535;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function void note_sample(logic signed [15:0] ax, ay, az);
      longint x, y, z, rad, rl, pt;
      angle_pair_type p;
      x = ax;
      y = ay;
      z = az;
      if (offset_on) begin
         x = clip17(x - off_x);
         y = clip17(y - off_y);
         z = clip17(z - off_z);
      end
      rl = centideg(vector_angle(y * 16384, z * 16384), 18000);
      rad = int_root((longint'(y * y) + longint'(z * z)) << 28);
      pt = centideg(vector_angle(-x * 16384, rad), 9000);
      p.roll = rl[15:0];
      p.pitch = pt[14:0];
      pending.push_back(p);
   endfunction

   function void check_angles(logic signed [15:0] roll, logic signed [14:0] pitch);
      angle_pair_type p;
      if (pending.size() == 0) begin
         orphans++;
         if (mismatches + orphans <= 10)
            $display("unexpected result roll=%0d pitch=%0d", roll, pitch);
         return;
      end
      p = pending.pop_front();
      if (roll !== p.roll || pitch !== p.pitch) begin
         mismatches++;
         if (mismatches + orphans <= 10)
            $display("mismatch: roll exp %0d got %0d, pitch exp %0d got %0d",
                     p.roll, roll, p.pitch, pitch);
      end
   endfunction
endclass

// ===== tb/accel_tilt_roll_pitch_tb.sv =====
`timescale 1ns / 1ps
module accel_tilt_roll_pitch_tb;
   import atrp_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   bit stall_on = 0;
   int stall_mode = 0;
   int idle_cycles = 0;
   bit timed_out = 0;

   atrp_req_if req_chan ();
   atrp_rsp_if rsp_chan ();

   accel_tilt_roll_pitch DUT (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   tilt_scoreboard angles = new();

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      req_chan.valid = 0;
      req_chan.accel_x = 0;
      req_chan.accel_y = 0;
      req_chan.accel_z = 0;
      rsp_chan.ready = 0;
   end

   // receiver stall pattern
   int phase_cnt = 0;
   always @(posedge clock) begin
      phase_cnt <= phase_cnt + 1;
      if (!stall_on) rsp_chan.ready <= 1;
      else case (stall_mode)
         0: rsp_chan.ready <= 1;
         1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_chan.ready <= (phase_cnt % 7) < 3;
         default: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
      endcase
      if ((phase_cnt % 300) == 0) stall_mode <= $urandom_range(0, 3);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         angles.check_angles(rsp_chan.roll_centideg, rsp_chan.pitch_centideg);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("accel_tilt_roll_pitch_tb NOT OK");
         $finish;
      end
   end

   int burst_left = 0;

   task automatic send_sample(logic signed [15:0] ax, ay, az);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) begin
            req_chan.valid <= 0;
            @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1;
      req_chan.accel_x <= ax;
      req_chan.accel_y <= ay;
      req_chan.accel_z <= az;
      do @(posedge clock); while (!req_chan.ready);
      angles.note_sample(ax, ay, az);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] wdata);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= wdata;
      @(posedge clock);
      csr_we <= 0;
      angles.write_reg(idx, wdata);
      @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (angles.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [15:0] edge_val();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0001;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_sample(edge_val(), edge_val(), edge_val());
         else if ($urandom_range(0, 9) == 0)
            send_sample(16'($urandom_range(0, 16'hFFFF)), 0, 0);
         else if ($urandom_range(0, 4) == 0)
            send_sample(16'($urandom_range(0, 16'hFFFF) >>> 8),
                        16'($urandom_range(0, 255) - 128),
                        16'($urandom_range(0, 255) - 128));
         else
            send_sample(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                        16'($urandom_range(0, 16'hFFFF)));
      end
   endtask

   initial begin
      angles.new_reset();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero vectors, axis directions, extremes
      send_sample(0, 0, 0);
      send_sample(100, 0, 0);
      send_sample(-100, 0, 0);
      send_sample(0, 0, -500);
      send_sample(0, 0, 500);
      send_sample(0, 500, 0);
      send_sample(0, -500, 0);
      send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_sample(16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(16'sh8000, 0, 16'sh8000);
      send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_sample(1, -1, -1);
      send_sample(-1, 1, 0);
      send_sample(1000, 0, -1);
      send_sample(0, -1, -32768);
      drain();

      // offsets at extremes: widest differences, which still fit in 17 bits
      write_csr(CSR_OFFSET_X, 16'h8000);
      write_csr(CSR_OFFSET_Y, 16'h7FFF);
      write_csr(CSR_OFFSET_Z, 16'h8000);
      write_csr(CSR_OFFSET_ENABLE, 16'hFFFF);
      send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
      send_sample(0, 0, 0);
      send_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
      drain();

      stall_on = 1;
      random_phase(300);
      drain();
      write_csr(CSR_OFFSET_X, 16'($urandom_range(0, 16'hFFFF)));
      write_csr(CSR_OFFSET_Y, 16'($urandom_range(0, 16'hFFFF)));
      write_csr(CSR_OFFSET_Z, 16'($urandom_range(0, 16'hFFFF)));
      random_phase(250);
      drain();
      write_csr(CSR_OFFSET_ENABLE, 16'hFFFE);
      random_phase(250);
      drain();
      write_csr(CSR_OFFSET_X, 16'h7FFF);
      write_csr(CSR_OFFSET_Y, 16'h8000);
      write_csr(CSR_OFFSET_Z, 16'h0001);
      write_csr(CSR_OFFSET_ENABLE, 16'h0001);
      random_phase(230);
      drain();

      if (angles.mismatches == 0 && angles.orphans == 0 && angles.pending.size() == 0)
         $display("accel_tilt_roll_pitch_tb OK");
      else
         $display("accel_tilt_roll_pitch_tb NOT OK");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/atrp_pkg.sv
rtl/atrp_if.sv
rtl/accel_tilt_roll_pitch.sv
rtl/atrp_check.sv
tb/tilt_scoreboard.sv
tb/accel_tilt_roll_pitch_tb.sv
